FILE: design/sorted_priority_queue_unique_key_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared clocking and reset handling for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIQUE_KEY_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIQUE_KEY_TOP_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int KEY_W        = 16;
	localparam int PRIO_W       = 16;
	localparam int KIND_W       = 2;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 5;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]  seat;
		logic [PRIO_W-1:0] prio;
	} ent_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic              cmp;
		logic              ins;
		logic              rem;
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] prio;
	} cell_ctl_t;

endpackage

FILE: design/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if
// Request and response channels of the sorted priority queue.
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic                       valid;
	logic                       ready;
	logic [spq_pkg::KIND_W-1:0] kind;
	logic [spq_pkg::KEY_W-1:0]  seat_key;
	logic [spq_pkg::PRIO_W-1:0] priority_req;

	modport source (output valid, kind, seat_key, priority_req, input ready);
	modport sink (input valid, kind, seat_key, priority_req, output ready);
endinterface

interface spq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [spq_pkg::STATUS_W-1:0] status;
	logic [spq_pkg::KEY_W-1:0]    out_seat;
	logic [spq_pkg::PRIO_W-1:0]   out_priority;
	logic [spq_pkg::COUNT_W-1:0]  count;

	modport source (output valid, status, out_seat, out_priority, count, input ready);
	modport sink (input valid, status, out_seat, out_priority, count, output ready);
endinterface

FILE: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: compares against the broadcast request, then shifts.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic               live,
	input  logic               left_shift,
	input  spq_pkg::ent_t      left_ent,
	input  spq_pkg::ent_t      right_ent,
	output spq_pkg::ent_t      ent,
	output logic               shift,
	output logic               hit
);

	spq_pkg::ent_t ent_q;
	logic          shift_q;
	logic          hit_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			hit_q   <= live && (ent_q.seat == ctl.key);
			shift_q <= !live || (ent_q.prio > ctl.prio);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && shift_q) begin
			if (left_shift) begin
				ent_q <= left_ent;
			end else begin
				ent_q <= '{seat: ctl.key, prio: ctl.prio};
			end
		end else if (ctl.rem) begin
			ent_q <= right_ent;
		end
	end

	assign ent   = ent_q;
	assign shift = shift_q;
	assign hit   = hit_q;

endmodule

FILE: design/spq_chain.sv
// ----------------------------------------------------------------------------
// spq_chain
// Row of queue cells, front at index zero, with the key match reduction.
// ----------------------------------------------------------------------------
module spq_chain #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0]   count,
	output spq_pkg::ent_t      front,
	output logic               front_shift,
	output logic               any_hit
);

	spq_pkg::ent_t         ents [CAPACITY];
	logic [CAPACITY-1:0]   shifts;
	logic [CAPACITY-1:0]   hits;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::ent_t left_ent;
		spq_pkg::ent_t right_ent;
		logic          left_shift;
		logic          live;

		assign live = count > CNT_W'(i);

		if (i == 0) begin : g_first
			assign left_ent   = '0;
			assign left_shift = 1'b0;
		end else begin : g_mid
			assign left_ent   = ents[i-1];
			assign left_shift = shifts[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_ent = '0;
		end else begin : g_inner
			assign right_ent = ents[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.live       (live),
			.left_shift (left_shift),
			.left_ent   (left_ent),
			.right_ent  (right_ent),
			.ent        (ents[i]),
			.shift      (shifts[i]),
			.hit        (hits[i])
		);
	end

	assign front       = ents[0];
	assign front_shift = shifts[0];
	assign any_hit     = |hits;

endmodule

FILE: design/sorted_priority_queue_unique_key_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unique_key_top
// Bounded priority queue, sorted by priority, unique seat keys.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries kind (insert, remove front, peek front), seat_key and
//   priority_req. rsp channel returns one response per request: status,
//   out_seat, out_priority (removed entry, or front entry after the
//   operation) and count. Equal priorities leave in arrival order.
//   Timing: a request passes through the accept, compare and update states.
//   In the compare state every cell matches the key and priority; in the
//   update state the cells shift in one step and the response register
//   loads. The response is visible the cycle after the update. No new
//   request is taken until the update ends, as the compare/update sequence
//   over the cell row is shared by all requests.
//   The next request is taken while a response still waits in the output
//   register; a stalled receiver holds the update cycle until it drains.
//   Reset clears the entry count and the response valid; cell contents are
//   only read below the count.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unique_key_top_assert.svh"

module sorted_priority_queue_unique_key_top #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	spq_req_if.sink       req,
	spq_rsp_if.source     rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0]                   st_q;
	logic [CNT_W-1:0]             count_q;
	logic                         rsp_valid_q;
	logic [spq_pkg::KIND_W-1:0]   kind_q;
	logic [spq_pkg::KEY_W-1:0]    key_q;
	logic [spq_pkg::PRIO_W-1:0]   prio_q;
	logic [spq_pkg::STATUS_W-1:0] status_q;
	spq_pkg::ent_t                res_q;

	spq_pkg::cell_ctl_t           ctl;
	spq_pkg::ent_t                front;
	logic                         front_shift;
	logic                         any_hit;
	logic                         stall;
	logic                         done;
	logic                         do_ins;
	logic                         do_rem;
	logic [spq_pkg::STATUS_W-1:0] status_d;
	spq_pkg::ent_t                res_d;
	logic [CNT_W-1:0]             count_d;
	spq_pkg::ent_t                new_ent;

	assign req.ready = (st_q == S_IDLE);
	assign stall     = rsp_valid_q && !rsp.ready;
	assign done      = (st_q == S_UPD) && !stall;
	assign new_ent   = '{seat: key_q, prio: prio_q};

	always_comb begin
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		status_d = spq_pkg::ST_OK;
		res_d    = front;
		count_d  = count_q;
		case (kind_q)
			spq_pkg::KIND_INSERT: begin
				if (any_hit) begin
					status_d = spq_pkg::ST_DUP;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					status_d = spq_pkg::ST_FULL;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + CNT_W'(1);
					if (front_shift) begin
						res_d = new_ent;
					end
				end
			end
			spq_pkg::KIND_REMOVE: begin
				if (count_q == '0) begin
					status_d = spq_pkg::ST_EMPTY;
					res_d    = '0;
				end else begin
					do_rem  = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				if (count_q == '0) begin
					status_d = spq_pkg::ST_EMPTY;
					res_d    = '0;
				end
			end
		endcase
	end

	assign ctl.cmp  = (st_q == S_CMP);
	assign ctl.ins  = done && do_ins;
	assign ctl.rem  = done && do_rem;
	assign ctl.key  = key_q;
	assign ctl.prio = prio_q;

	spq_chain #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_chain (
		.clk         (clk),
		.ctl         (ctl),
		.count       (count_q),
		.front       (front),
		.front_shift (front_shift),
		.any_hit     (any_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (req.valid) begin
						st_q <= S_CMP;
					end
				end
				S_CMP: begin
					st_q <= S_UPD;
				end
				S_UPD: begin
					if (!stall) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
			if (done) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q <= req.kind;
			key_q  <= req.seat_key;
			prio_q <= req.priority_req;
		end
		if (done) begin
			status_q <= status_d;
			res_q    <= res_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_seat     = res_q.seat;
	assign rsp.out_priority = res_q.prio;
	assign rsp.count        = spq_pkg::COUNT_W'(count_q);

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`SPQ_ASSERT_NEXT(a_ins_grows, done && do_ins, count_q == $past(count_q) + CNT_W'(1), "insert did not grow count")
	`SPQ_ASSERT_NEXT(a_rsp_loaded, done, rsp_valid_q && (st_q == S_IDLE), "response not loaded after update")
	`SPQ_ASSERT_NOW(a_no_double_op, 1'b1, !(ctl.ins && ctl.rem) && !(ctl.cmp && (ctl.ins || ctl.rem)), "conflicting cell commands")

endmodule
